>>> hw/rtl/pts_pkg.sv
// pts_pkg: shared types and constants for the priority task scheduler
// no dependencies

package pts_pkg;

  localparam int TaskCount    = 16;
  localparam int PriorityBits = 4;
  localparam int SignalBits   = 32;

  typedef enum logic [2:0] {
    KIND_CREATE   = 3'd0,
    KIND_CANCEL   = 3'd1,
    KIND_SIGNAL   = 3'd2,
    KIND_WAIT     = 3'd3,
    KIND_YIELD    = 3'd4,
    KIND_EXIT     = 3'd5,
    KIND_DISPATCH = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    ST_DEAD    = 3'd0,
    ST_EXITED  = 3'd1,
    ST_WAITING = 3'd2,
    ST_READY   = 3'd3,
    ST_RUNNING = 3'd4
  } task_state_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD_ID  = 2'd1,
    STATUS_BAD_PRI = 2'd2,
    STATUS_IN_USE  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CTL_IDLE,
    CTL_EXEC,
    CTL_SCAN,
    CTL_POP,
    CTL_OUT
  } ctl_state_e;

  localparam logic CFG_MOST  = 1'b0;
  localparam logic CFG_LEAST = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic scan_start;
    logic scan_step;
    logic pop;
    logic out_load;
  } pts_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_dispatch;
    logic scan_hit;
    logic scan_done;
  } pts_status_t;

endpackage

>>> hw/rtl/pts_ctrl.sv
// pts_ctrl: event sequencing state machine
// depends on pts_pkg

module pts_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_fire_i,
  input  logic                out_busy_i,
  input  pts_pkg::pts_status_t sts_i,
  output pts_pkg::pts_cmd_t   cmd_o,
  output logic                idle_o
);

  pts_pkg::ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pts_pkg::CTL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      pts_pkg::CTL_IDLE: if (in_fire_i) state_d = pts_pkg::CTL_EXEC;
      pts_pkg::CTL_EXEC: begin
        if (sts_i.need_dispatch) state_d = pts_pkg::CTL_SCAN;
        else state_d = pts_pkg::CTL_OUT;
      end
      pts_pkg::CTL_SCAN: begin
        if (sts_i.scan_hit) state_d = pts_pkg::CTL_POP;
        else if (sts_i.scan_done) state_d = pts_pkg::CTL_OUT;
      end
      pts_pkg::CTL_POP: state_d = pts_pkg::CTL_OUT;
      pts_pkg::CTL_OUT: if (!out_busy_i) state_d = pts_pkg::CTL_IDLE;
      default: state_d = pts_pkg::CTL_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    idle_o = 1'b0;
    case (state_q)
      pts_pkg::CTL_IDLE: begin
        idle_o = 1'b1;
        cmd_o.load = in_fire_i;
      end
      pts_pkg::CTL_EXEC: begin
        cmd_o.exec = 1'b1;
        cmd_o.scan_start = sts_i.need_dispatch;
      end
      pts_pkg::CTL_SCAN: cmd_o.scan_step = !sts_i.scan_hit;
      pts_pkg::CTL_POP: cmd_o.pop = 1'b1;
      pts_pkg::CTL_OUT: cmd_o.out_load = !out_busy_i;
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/pts_dpath.sv
// pts_dpath: task table, ready lists and result register
// depends on pts_pkg

module pts_dpath #(
  parameter int TASK_COUNT    = pts_pkg::TaskCount,
  parameter int PRIORITY_BITS = pts_pkg::PriorityBits,
  parameter int SIGNAL_BITS   = pts_pkg::SignalBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pts_pkg::pts_cmd_t    cmd_i,
  output pts_pkg::pts_status_t sts_o,
  input  logic [2:0]           kind_i,
  input  logic [3:0]           task_id_i,
  input  logic                 to_self_i,
  input  logic signed [3:0]    priority_req_i,
  input  logic [31:0]          signal_mask_i,
  input  logic [31:0]          clear_mask_i,
  input  logic                 wait_all_i,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [3:0]           cfg_data_i,
  output logic [1:0]           status_o,
  output logic                 switched_o,
  output logic                 next_valid_o,
  output logic [3:0]           next_task_o,
  output logic [31:0]          current_signals_o
);

  localparam int TW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
  localparam int LISTS = 1 << PRIORITY_BITS;
  localparam int LW = PRIORITY_BITS;

  logic [2:0]             st_q   [TASK_COUNT];
  logic [LW-1:0]          pri_q  [TASK_COUNT];
  logic [SIGNAL_BITS-1:0] rcv_q  [TASK_COUNT];
  logic [SIGNAL_BITS-1:0] awt_q  [TASK_COUNT];
  logic                   all_q  [TASK_COUNT];
  logic [TW-1:0]          nxt_q  [TASK_COUNT];
  logic [TW-1:0]          prv_q  [TASK_COUNT];
  logic [TW-1:0]          head_q [LISTS];
  logic [TW-1:0]          tail_q [LISTS];
  logic [LISTS-1:0]       used_q;
  logic                   run_v_q;
  logic [TW-1:0]          run_q;
  logic signed [3:0]      most_q, least_q;

  logic [2:0]             kind_q;
  logic [3:0]             id_q;
  logic                   self_q;
  logic signed [3:0]      preq_q;
  logic [SIGNAL_BITS-1:0] sig_q, clr_q;
  logic                   wall_q;
  logic [1:0]             status_q;
  logic                   sw_q;
  logic [LW-1:0]          scan_q;
  logic [LW:0]            cnt_q;

  logic [1:0]  res_status_q;
  logic        res_sw_q, res_v_q;
  logic [3:0]  res_task_q;
  logic [31:0] res_sig_q;

  // target resolution
  logic          tgt_ok;
  logic [TW-1:0] tgt;
  always_comb begin
    if (self_q) begin
      tgt_ok = run_v_q;
      tgt = run_q;
    end else begin
      tgt_ok = ({28'd0, id_q} < 32'(TASK_COUNT));
      tgt = id_q[TW-1:0];
    end
  end

  logic [SIGNAL_BITS-1:0] sig_new, wrcv, g_sig, g_wt;
  logic                   met_sig, met_wait;
  logic [2:0]             tst;
  always_comb begin
    tst = st_q[tgt];
    sig_new = rcv_q[tgt] | sig_q;
    g_sig = sig_new & awt_q[tgt];
    met_sig = all_q[tgt] ? (g_sig == awt_q[tgt]) : (g_sig != '0);
    wrcv = rcv_q[run_q] & ~clr_q;
    g_wt = wrcv & sig_q;
    met_wait = wall_q ? (g_wt == sig_q) : (g_wt != '0);
  end

  logic need_d;
  always_comb begin
    need_d = 1'b0;
    case (pts_pkg::kind_e'(kind_q))
      pts_pkg::KIND_CANCEL: need_d = tgt_ok && (tst == pts_pkg::ST_RUNNING);
      pts_pkg::KIND_WAIT: need_d = run_v_q && !met_wait;
      pts_pkg::KIND_YIELD, pts_pkg::KIND_EXIT: need_d = run_v_q;
      pts_pkg::KIND_DISPATCH: need_d = !run_v_q;
      default: need_d = 1'b0;
    endcase
  end

  assign sts_o.need_dispatch = need_d;
  assign sts_o.scan_hit = used_q[scan_q];
  assign sts_o.scan_done = (cnt_q == (LW+1)'(1));

  logic [TW-1:0] pop_t;
  assign pop_t = head_q[scan_q];

  // list operations share one op each cycle
  logic          do_app, do_rem;
  logic [TW-1:0] op_t;
  always_comb begin
    do_app = 1'b0;
    do_rem = 1'b0;
    op_t = tgt;
    if (cmd_i.exec) begin
      case (pts_pkg::kind_e'(kind_q))
        pts_pkg::KIND_CREATE: begin
          op_t = id_q[TW-1:0];
          do_app = ({28'd0, id_q} < 32'(TASK_COUNT)) &&
                   !(preq_q < most_q || preq_q > least_q) &&
                   (st_q[id_q[TW-1:0]] == pts_pkg::ST_DEAD ||
                    st_q[id_q[TW-1:0]] == pts_pkg::ST_EXITED);
        end
        pts_pkg::KIND_CANCEL: do_rem = tgt_ok && (tst == pts_pkg::ST_READY);
        pts_pkg::KIND_SIGNAL: do_app = tgt_ok && (tst == pts_pkg::ST_WAITING) && met_sig;
        pts_pkg::KIND_YIELD: begin
          op_t = run_q;
          do_app = run_v_q;
        end
        default: ;
      endcase
    end else if (cmd_i.pop) begin
      op_t = pop_t;
      do_rem = 1'b1;
    end
  end

  logic [LW-1:0] app_pri, rem_pri;
  logic [LW-1:0] preq_u;
  assign preq_u = LW'(preq_q);
  assign app_pri = (pts_pkg::kind_e'(kind_q) == pts_pkg::KIND_CREATE && cmd_i.exec)
                   ? preq_u : pri_q[op_t];
  assign rem_pri = pri_q[op_t];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TASK_COUNT; i++) begin
        st_q[i] <= pts_pkg::ST_DEAD;
        pri_q[i] <= '0;
        rcv_q[i] <= '0;
        awt_q[i] <= '0;
        all_q[i] <= 1'b0;
      end
      used_q <= '0;
      run_v_q <= 1'b0;
      run_q <= '0;
      most_q <= -4'sd8;
      least_q <= 4'sd7;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == pts_pkg::CFG_MOST) most_q <= cfg_data_i;
        else least_q <= cfg_data_i;
      end
      if (cmd_i.exec) begin
        case (pts_pkg::kind_e'(kind_q))
          pts_pkg::KIND_CREATE: if (do_app) begin
            pri_q[op_t] <= preq_u;
            rcv_q[op_t] <= '0;
            awt_q[op_t] <= '0;
            all_q[op_t] <= 1'b0;
            st_q[op_t] <= pts_pkg::ST_READY;
          end
          pts_pkg::KIND_CANCEL: if (tgt_ok) begin
            st_q[tgt] <= pts_pkg::ST_DEAD;
            if (tst == pts_pkg::ST_RUNNING) run_v_q <= 1'b0;
          end
          pts_pkg::KIND_SIGNAL: if (tgt_ok) begin
            rcv_q[tgt] <= sig_new;
            if (do_app) st_q[tgt] <= pts_pkg::ST_READY;
          end
          pts_pkg::KIND_WAIT: if (run_v_q) begin
            awt_q[run_q] <= sig_q;
            all_q[run_q] <= wall_q;
            rcv_q[run_q] <= wrcv;
            if (!met_wait) begin
              st_q[run_q] <= pts_pkg::ST_WAITING;
              run_v_q <= 1'b0;
            end
          end
          pts_pkg::KIND_YIELD: if (run_v_q) begin
            st_q[run_q] <= pts_pkg::ST_READY;
            run_v_q <= 1'b0;
          end
          pts_pkg::KIND_EXIT: if (run_v_q) begin
            st_q[run_q] <= pts_pkg::ST_EXITED;
            run_v_q <= 1'b0;
          end
          default: ;
        endcase
      end
      if (cmd_i.pop) begin
        st_q[pop_t] <= pts_pkg::ST_RUNNING;
        run_q <= pop_t;
        run_v_q <= 1'b1;
      end
      if (do_app) begin
        used_q[app_pri] <= 1'b1;
      end else if (do_rem && used_q[rem_pri] && head_q[rem_pri] == op_t &&
                   tail_q[rem_pri] == op_t) begin
        used_q[rem_pri] <= 1'b0;
      end
    end
  end

  // links and list ends carry no reset
  always_ff @(posedge clk_i) begin
    if (do_app) begin
      if (!used_q[app_pri]) begin
        head_q[app_pri] <= op_t;
      end else begin
        nxt_q[tail_q[app_pri]] <= op_t;
        prv_q[op_t] <= tail_q[app_pri];
      end
      tail_q[app_pri] <= op_t;
    end else if (do_rem && used_q[rem_pri]) begin
      if (head_q[rem_pri] == op_t) begin
        if (tail_q[rem_pri] != op_t) head_q[rem_pri] <= nxt_q[op_t];
      end else if (tail_q[rem_pri] == op_t) begin
        tail_q[rem_pri] <= prv_q[op_t];
      end else begin
        nxt_q[prv_q[op_t]] <= nxt_q[op_t];
        prv_q[nxt_q[op_t]] <= prv_q[op_t];
      end
    end
  end

  // latched event, status flags and scan pointer
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      id_q <= task_id_i;
      self_q <= to_self_i;
      preq_q <= priority_req_i;
      sig_q <= SIGNAL_BITS'(signal_mask_i);
      clr_q <= SIGNAL_BITS'(clear_mask_i);
      wall_q <= wait_all_i;
    end
    if (cmd_i.exec) begin
      status_q <= pts_pkg::STATUS_OK;
      sw_q <= 1'b0;
      case (pts_pkg::kind_e'(kind_q))
        pts_pkg::KIND_CREATE: begin
          if (!({28'd0, id_q} < 32'(TASK_COUNT))) status_q <= pts_pkg::STATUS_BAD_ID;
          else if (preq_q < most_q || preq_q > least_q) status_q <= pts_pkg::STATUS_BAD_PRI;
          else if (!do_app) status_q <= pts_pkg::STATUS_IN_USE;
        end
        pts_pkg::KIND_CANCEL: begin
          if (!tgt_ok) status_q <= pts_pkg::STATUS_BAD_ID;
          sw_q <= need_d;
        end
        pts_pkg::KIND_SIGNAL: if (!tgt_ok) status_q <= pts_pkg::STATUS_BAD_ID;
        pts_pkg::KIND_WAIT: begin
          if (!run_v_q) status_q <= pts_pkg::STATUS_BAD_ID;
          sw_q <= need_d;
        end
        pts_pkg::KIND_YIELD, pts_pkg::KIND_EXIT: begin
          if (!run_v_q) status_q <= pts_pkg::STATUS_BAD_ID;
          sw_q <= run_v_q;
        end
        default: ;
      endcase
    end
    if (cmd_i.scan_start) begin
      scan_q <= LW'(LISTS >> 1);
      cnt_q <= (LW+1)'(LISTS);
    end else if (cmd_i.scan_step) begin
      scan_q <= scan_q + LW'(1);
      cnt_q <= cnt_q - (LW+1)'(1);
    end
  end

  logic [3:0]  out_task;
  logic [31:0] out_sig;
  always_comb begin
    out_task = run_v_q ? 4'(run_q) : 4'd0;
    out_sig = run_v_q ? 32'(rcv_q[run_q]) : 32'd0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      res_status_q <= status_q;
      res_sw_q <= sw_q;
      res_v_q <= run_v_q;
      res_task_q <= out_task;
      res_sig_q <= out_sig;
    end
  end

  assign status_o = res_status_q;
  assign switched_o = res_sw_q;
  assign next_valid_o = res_v_q;
  assign next_task_o = res_task_q;
  assign current_signals_o = res_sig_q;

endmodule

>>> hw/rtl/priority_task_scheduler.sv
// priority_task_scheduler: top level of the hardware task scheduler
// depends on pts_pkg, pts_ctrl, pts_dpath
//
// channel  dir  handshake               payload
// s_axis   in   s_axis_tvalid/tready    event word
// m_axis   out  m_axis_tvalid/tready    result word
// cfg      in   cfg_we_i                priority range registers
//
// an event is latched, executed and passed to the output register; when a dispatch
// runs, a scan of the ready lists and, for a found task, a pop come in between.
// the result waits in an output register while the next event is taken; a new
// result is held back until the previous word is handed over.
// reset empties all ready lists and leaves the block idle.

module priority_task_scheduler #(
  parameter int TASK_COUNT    = pts_pkg::TaskCount,
  parameter int PRIORITY_BITS = pts_pkg::PriorityBits,
  parameter int SIGNAL_BITS   = pts_pkg::SignalBits
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // task_id[3:0], to_self[4], priority_req[8:5], signal_mask[40:9],
  // clear_mask[72:41], wait_all[73], zero fill
  input  logic [79:0]  s_axis_tdata,
  // kind[2:0]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[1:0], switched[2], next_valid[3], next_task[7:4],
  // current_signals[39:8]
  output logic [39:0]  m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [3:0]   cfg_data_i
);

  pts_pkg::pts_cmd_t    cmd;
  pts_pkg::pts_status_t sts;
  logic idle, in_fire, out_v_q;

  assign s_axis_tready = idle;
  assign in_fire = s_axis_tvalid && idle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (cmd.out_load) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_v_q;

  pts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .out_busy_i (out_v_q && !m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .idle_o     (idle)
  );

  pts_dpath #(
    .TASK_COUNT    (TASK_COUNT),
    .PRIORITY_BITS (PRIORITY_BITS),
    .SIGNAL_BITS   (SIGNAL_BITS)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .kind_i            (s_axis_tuser),
    .task_id_i         (s_axis_tdata[3:0]),
    .to_self_i         (s_axis_tdata[4]),
    .priority_req_i    (s_axis_tdata[8:5]),
    .signal_mask_i     (s_axis_tdata[40:9]),
    .clear_mask_i      (s_axis_tdata[72:41]),
    .wait_all_i        (s_axis_tdata[73]),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .status_o          (m_axis_tdata[1:0]),
    .switched_o        (m_axis_tdata[2]),
    .next_valid_o      (m_axis_tdata[3]),
    .next_task_o       (m_axis_tdata[7:4]),
    .current_signals_o (m_axis_tdata[39:8])
  );

endmodule

>>> bench/pts_checker.sv
// pts_checker: watches the event, result and config channels of the scheduler,
// predicts each result word from its own task table and compares in order
// depends on pts_pkg

module pts_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,
  input  logic [2:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [3:0]  cfg_data_i,
  output int          fail_count,
  output int          pending,
  output int          checked,
  output int          switches
);
  import pts_pkg::*;

  localparam int Lists = 1 << PriorityBits;

  task_state_e       tstate   [TaskCount];
  logic [3:0]        tprio    [TaskCount];
  logic [31:0]       sig_recv [TaskCount];
  logic [31:0]       sig_wait [TaskCount];
  logic              mode_all [TaskCount];
  logic [3:0]        link_nxt [TaskCount];
  logic [3:0]        link_prv [TaskCount];
  logic [3:0]        head     [Lists];
  logic [3:0]        tail     [Lists];
  logic              used     [Lists];
  logic              running;
  logic [3:0]        cur_task;
  logic signed [3:0] pri_most;
  logic signed [3:0] pri_least;
  logic [39:0]       expected_results[$];

  function automatic void ready_push(logic [3:0] t);
    logic [3:0] q;
    q = tprio[t];
    if (!used[q]) begin
      head[q] = t;
      tail[q] = t;
      used[q] = 1'b1;
    end else begin
      link_nxt[tail[q]] = t;
      link_prv[t] = tail[q];
      tail[q] = t;
    end
  endfunction

  function automatic void ready_unlink(logic [3:0] t);
    logic [3:0] q;
    q = tprio[t];
    if (!used[q]) return;
    if (head[q] == t) begin
      if (tail[q] == t) used[q] = 1'b0;
      else head[q] = link_nxt[t];
    end else if (tail[q] == t) begin
      tail[q] = link_prv[t];
    end else begin
      link_nxt[link_prv[t]] = link_nxt[t];
      link_prv[link_nxt[t]] = link_prv[t];
    end
  endfunction

  // most negative priority first: list 8 (-8) upward, wrapping
  function automatic void pick_next();
    logic [3:0] i;
    logic [3:0] t;
    running = 1'b0;
    i = 4'd8;
    for (int n = 0; n < Lists; n++) begin
      if (used[i]) begin
        t = head[i];
        ready_unlink(t);
        tstate[t] = ST_RUNNING;
        cur_task = t;
        running = 1'b1;
        return;
      end
      i = i + 4'd1;
    end
  endfunction

  function automatic logic wait_done(logic [3:0] t);
    logic [31:0] g;
    g = sig_recv[t] & sig_wait[t];
    return mode_all[t] ? (g == sig_wait[t]) : (g != 0);
  endfunction

  function automatic logic [39:0] sched_step(kind_e k, logic [79:0] d);
    logic [3:0]        id;
    logic              self;
    logic signed [3:0] pri;
    logic [31:0]       sig;
    logic [31:0]       clr;
    logic              all;
    status_e           st;
    logic              sw;
    logic              ok;
    logic [3:0]        t;
    id = d[3:0]; self = d[4]; pri = d[8:5]; sig = d[40:9]; clr = d[72:41]; all = d[73];
    st = STATUS_OK; sw = 1'b0;
    ok = self ? running : 1'b1;
    t = self ? cur_task : id;
    case (k)
      KIND_CREATE: begin
        t = id;
        if (pri < pri_most || pri > pri_least) st = STATUS_BAD_PRI;
        else if (tstate[t] != ST_DEAD && tstate[t] != ST_EXITED) st = STATUS_IN_USE;
        else begin
          tprio[t] = pri;
          sig_recv[t] = '0;
          sig_wait[t] = '0;
          mode_all[t] = 1'b0;
          tstate[t] = ST_READY;
          ready_push(t);
        end
      end
      KIND_CANCEL: begin
        if (!ok) st = STATUS_BAD_ID;
        else begin
          if (tstate[t] == ST_READY) ready_unlink(t);
          else if (tstate[t] == ST_RUNNING) sw = 1'b1;
          tstate[t] = ST_DEAD;
          if (sw) pick_next();
        end
      end
      KIND_SIGNAL: begin
        if (!ok) st = STATUS_BAD_ID;
        else begin
          sig_recv[t] |= sig;
          if (tstate[t] == ST_WAITING && wait_done(t)) begin
            tstate[t] = ST_READY;
            ready_push(t);
          end
        end
      end
      KIND_WAIT: begin
        if (!running) st = STATUS_BAD_ID;
        else begin
          t = cur_task;
          sig_wait[t] = sig;
          mode_all[t] = all;
          sig_recv[t] &= ~clr;
          if (!wait_done(t)) begin
            tstate[t] = ST_WAITING;
            sw = 1'b1;
            pick_next();
          end
        end
      end
      KIND_YIELD: begin
        if (!running) st = STATUS_BAD_ID;
        else begin
          tstate[cur_task] = ST_READY;
          ready_push(cur_task);
          sw = 1'b1;
          pick_next();
        end
      end
      KIND_EXIT: begin
        if (!running) st = STATUS_BAD_ID;
        else begin
          tstate[cur_task] = ST_EXITED;
          sw = 1'b1;
          pick_next();
        end
      end
      KIND_DISPATCH: if (!running) pick_next();
      default: ;
    endcase
    return {running ? sig_recv[cur_task] : 32'd0, running ? cur_task : 4'd0,
            running, sw, st};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [39:0] exp_word;
    if (!rst_ni) begin
      for (int i = 0; i < TaskCount; i++) begin
        tstate[i] = ST_DEAD; tprio[i] = '0; sig_recv[i] = '0; sig_wait[i] = '0;
        mode_all[i] = 1'b0; link_nxt[i] = '0; link_prv[i] = '0;
      end
      for (int i = 0; i < Lists; i++) begin
        head[i] = '0; tail[i] = '0; used[i] = 1'b0;
      end
      running = 1'b0; cur_task = '0;
      pri_most = -4'sd8; pri_least = 4'sd7;
      expected_results.delete();
      fail_count = 0; pending = 0; checked = 0; switches = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_MOST) pri_most = cfg_data_i;
        else pri_least = cfg_data_i;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result word %h", m_axis_tdata);
        end else begin
          exp_word = expected_results.pop_front();
          checked++;
          if (m_axis_tdata[2]) switches++;
          if (exp_word[1:0] !== m_axis_tdata[1:0] || exp_word[2] !== m_axis_tdata[2] ||
              exp_word[3] !== m_axis_tdata[3] || exp_word[7:4] !== m_axis_tdata[7:4] ||
              exp_word[39:8] !== m_axis_tdata[39:8]) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: status %0d/%0d sw %0d/%0d valid %0d/%0d task %0d/%0d sig %h/%h",
                       exp_word[1:0], m_axis_tdata[1:0], exp_word[2], m_axis_tdata[2],
                       exp_word[3], m_axis_tdata[3], exp_word[7:4], m_axis_tdata[7:4],
                       exp_word[39:8], m_axis_tdata[39:8]);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(sched_step(kind_e'(s_axis_tuser), s_axis_tdata));
      pending = expected_results.size();
    end
  end

endmodule

>>> bench/testbench.sv
// testbench: drives scheduler events and priority range settings, with random
// idling on both channels; depends on pts_pkg, priority_task_scheduler, pts_checker

module testbench;
  import pts_pkg::*;

  localparam int CycleLimit = 500000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [3:0]  cfg_data_i;
  logic        calm;
  int          fail_count, pending, checked, switches;
  int          cycles;
  int          sent;

  priority_task_scheduler u_top (.*);

  pts_checker u_chk (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    m_axis_tready <= calm || ($urandom_range(99) >= 28);
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [31:0] rand_mask();
    case ($urandom_range(4))
      0: return 32'd0;
      1: return 32'hffff_ffff;
      2: return $urandom();
      default: return 32'(4'($urandom()));
    endcase
  endfunction

  task automatic send_event(kind_e k, logic [3:0] id, logic self, logic [3:0] pri,
                            logic [31:0] sig, logic [31:0] clr, logic all);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= k;
    s_axis_tdata  <= {6'd0, all, clr, sig, pri, self, id};
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
    if (!calm && $urandom_range(99) < 28) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic set_range(logic [3:0] most, logic [3:0] least);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (25) @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= CFG_MOST; cfg_data_i <= most;
    @(posedge clk_i);
    cfg_idx_i <= CFG_LEAST; cfg_data_i <= least;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_events(int n);
    kind_e k;
    int    r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if      (r < 20) k = KIND_CREATE;
      else if (r < 35) k = KIND_DISPATCH;
      else if (r < 55) k = KIND_SIGNAL;
      else if (r < 70) k = KIND_WAIT;
      else if (r < 80) k = KIND_YIELD;
      else if (r < 88) k = KIND_EXIT;
      else if (r < 98) k = KIND_CANCEL;
      else             k = kind_e'(3'd7);
      send_event(k, 4'($urandom()), $urandom_range(99) < 30, 4'($urandom()),
                 rand_mask(), rand_mask(), 1'($urandom()));
    end
  endtask

  initial begin
    rst_ni = 1'b0; cycles = 0; sent = 0; calm = 1'b0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = '0;
    m_axis_tready = 1'b0; cfg_we_i = 1'b0; cfg_idx_i = 1'b0; cfg_data_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_event(KIND_CREATE, 4'd0, 1'b0, 4'h8, '0, '0, 1'b0);
    send_event(KIND_CREATE, 4'd0, 1'b0, 4'h3, '0, '0, 1'b0);
    send_event(KIND_CREATE, 4'd15, 1'b0, 4'h7, '0, '0, 1'b0);
    send_event(KIND_CREATE, 4'd2, 1'b0, 4'h0, '0, '0, 1'b0);
    send_event(KIND_WAIT, 4'd0, 1'b0, '0, 32'h1, '0, 1'b0);
    send_event(KIND_CANCEL, 4'd0, 1'b1, '0, '0, '0, 1'b0);
    send_event(kind_e'(3'd7), 4'd0, 1'b0, '0, '0, '0, 1'b0);
    send_event(KIND_DISPATCH, 4'd0, 1'b0, '0, '0, '0, 1'b0);
    send_event(KIND_DISPATCH, 4'd0, 1'b0, '0, '0, '0, 1'b0);
    send_event(KIND_SIGNAL, 4'd0, 1'b1, '0, 32'hffff_ffff, '0, 1'b0);
    send_event(KIND_WAIT, 4'd0, 1'b0, '0, 32'd0, '0, 1'b0);
    send_event(KIND_WAIT, 4'd0, 1'b0, '0, 32'd0, 32'hffff_ffff, 1'b1);
    send_event(KIND_WAIT, 4'd0, 1'b0, '0, 32'h3, 32'hffff_ffff, 1'b1);
    send_event(KIND_SIGNAL, 4'd15, 1'b0, '0, 32'h1, '0, 1'b0);
    send_event(KIND_SIGNAL, 4'd15, 1'b0, '0, 32'h2, '0, 1'b0);
    send_event(KIND_YIELD, 4'd0, 1'b0, '0, '0, '0, 1'b0);
    send_event(KIND_CANCEL, 4'd0, 1'b0, '0, '0, '0, 1'b0);
    send_event(KIND_CANCEL, 4'd0, 1'b0, '0, '0, '0, 1'b0);
    send_event(KIND_EXIT, 4'd0, 1'b0, '0, '0, '0, 1'b0);
    send_event(KIND_CANCEL, 4'd0, 1'b1, '0, '0, '0, 1'b0);
    send_event(KIND_EXIT, 4'd0, 1'b0, '0, '0, '0, 1'b0);
    send_event(KIND_SIGNAL, 4'd0, 1'b1, '0, 32'h1, '0, 1'b0);
    send_event(KIND_DISPATCH, 4'd0, 1'b0, '0, '0, '0, 1'b0);
    random_events(150);
    calm = 1'b1;
    random_events(100);
    calm = 1'b0;
    set_range(4'hE, 4'h3);
    random_events(120);
    set_range(4'h5, 4'hB);
    random_events(60);
    set_range(4'h7, 4'h7);
    random_events(100);
    set_range(4'h8, 4'h8);
    random_events(100);
    set_range(4'h8, 4'h7);
    random_events(100);
    s_axis_tvalid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    $display("sent %0d scheduler events over six priority ranges, checked %0d results",
             sent, checked);
    $display("%0d results gave up the running task", switches);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
